// ===== rtl/grid_ray_steer_top_assert.svh =====
// assertion macros for the grid ray steer block
// used by grid_ray_steer_top, no other dependencies
`ifndef GRID_RAY_STEER_TOP_ASSERT_SVH
`define GRID_RAY_STEER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define GRS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("assertion failed");
`else
`define GRS_ASSERT(lbl, clk, rstn, prop)
`define GRS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/grs_pkg.sv =====
// shared types, constants and state codes of the grid ray steer block
// no dependencies
`timescale 1ns / 1ps
package grs_pkg;

  localparam int GRID_CELLS_DEF = 1048576;
  localparam int MAX_STEPS_DEF  = 64;
  localparam int MUL_W          = 33;
  localparam int DIV_BITS       = 13;

  localparam logic [31:0] ORIGIN_RST = 32'd0;
  localparam logic [16:0] CELL_SIZE_RST = 17'd3277;
  localparam logic [12:0] GRID_DIM_RST = 13'd1024;
  localparam logic [30:0] REACH_RST = 31'd65536;

  localparam logic [1:0] CELL_FREE     = 2'd0;
  localparam logic [1:0] CELL_UNKNOWN  = 2'd1;
  localparam logic [1:0] CELL_OBSTACLE = 2'd2;

  localparam logic REQ_MAP_WRITE = 1'b0;
  localparam logic REQ_STEER     = 1'b1;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_CELL_SIZE,
    CFG_GRID_WIDTH,
    CFG_GRID_HEIGHT,
    CFG_REACH_LIMIT
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RR,
    ST_WR,
    ST_HR,
    ST_TOP,
    ST_MY,
    ST_SQX,
    ST_SQY,
    ST_CHK,
    ST_POS,
    ST_BND,
    ST_DIVX,
    ST_DIVY,
    ST_IDX,
    ST_ADR,
    ST_DEC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               req_type;
    logic [19:0]        cell_index;
    logic [1:0]         cell_value;
    logic signed [31:0] near_x;
    logic signed [31:0] near_y;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
  } grs_in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic               path_status;
  } grs_out_t;

endpackage

// ===== rtl/grs_mul.sv =====
// shared registered signed multiplier of the grid ray steer block
// depends on grs_pkg
`timescale 1ns / 1ps
module grs_mul (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic signed [grs_pkg::MUL_W-1:0]       a_i,
  input  logic signed [grs_pkg::MUL_W-1:0]       b_i,
  output logic signed [2*grs_pkg::MUL_W-1:0]     p_o
);

  logic signed [2*grs_pkg::MUL_W-1:0] p_q;
  logic signed [2*grs_pkg::MUL_W-1:0] p_d;

  // product register, one operand pair per cycle while en_i is high
  always_comb begin
    p_d = en_i ? a_i * b_i : p_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/grid_ray_steer_top.sv =====
// grid ray steer: occupancy grid store and steer walk over one shared multiplier
// after reset a clearing pass marks every cell unknown, with busy high
// a map write is stored from idle; a steer query walks up to MAX_STEPS steps
// over the shared multiplier and the bit-serial cell divider
// the result strobe done_o is registered from the done state after the walk ends; it cannot be held off
// asynchronous active-low reset clears control state and configuration to defaults
`timescale 1ns / 1ps
`include "grid_ray_steer_top_assert.svh"
module grid_ray_steer_top #(
  parameter int GRID_CELLS = grs_pkg::GRID_CELLS_DEF,
  parameter int MAX_STEPS  = grs_pkg::MAX_STEPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  grs_pkg::grs_in_t req_i,
  output logic             done_o,
  output grs_pkg::grs_out_t res_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int AW = $clog2(GRID_CELLS);
  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int MW = grs_pkg::MUL_W;

  // configuration
  logic signed [31:0] org_x_q, org_y_q;
  logic [16:0]        csize_q;
  logic [12:0]        gw_q, gh_q;
  logic [30:0]        reach_q;

  // sequencer and walk state
  grs_pkg::state_e    state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [SW-1:0]      steps_q, steps_d;
  logic               done_q, done_d;
  grs_pkg::grs_out_t  out_q, out_d;

  logic signed [31:0] nx_q, nx_d, ny_q, ny_d;
  logic signed [32:0] dx_q, dx_d, dy_q, dy_d;
  logic [16:0]        res_q, res_d, lam_q, lam_d;
  logic               found_q, found_d, stat_q, stat_d;
  logic [31:0]        bx_q, bx_d, by_q, by_d;
  logic [61:0]        rr_q, rr_d, sx_q, sx_d;
  logic [29:0]        wr_q, wr_d, hr_q, hr_d;
  logic signed [32:0] ox_q, ox_d, oy_q, oy_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d;
  logic [33:0]        dpx_q, dpx_d, dpy_q, dpy_d;
  logic [29:0]        rem_q, rem_d;
  logic [12:0]        quo_q, quo_d, qx_q, qx_d;
  logic [3:0]         k_q, k_d;

  // shared multiplier
  logic                     mul_en;
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [2*MW-1:0]   mul_p;

  // grid memory
  logic [1:0]    mem [GRID_CELLS];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [1:0]    mem_wdata, rd_q;

  // combinational helpers
  logic               accept;
  logic [32:0]        ax, ay;
  logic               far;
  logic [62:0]        dist_sq;
  logic signed [34:0] ddx, ddy;
  logic [29:0]        div_sh;
  logic               div_ge;
  logic [26:0]        cell_idx;
  logic               idx_out;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != grs_pkg::ST_IDLE);

  grs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .p_o    (mul_p)
  );

  // offset magnitudes for the reach test
  assign ax      = ox_q[32] ? 33'(-ox_q) : 33'(ox_q);
  assign ay      = oy_q[32] ? 33'(-oy_q) : 33'(oy_q);
  assign far     = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
  assign dist_sq = {1'b0, sx_q} + {1'b0, mul_p[61:0]};

  // distance from grid origin, clamped at zero in the position step
  assign ddx = 35'(cx_q) - 35'(org_x_q);
  assign ddy = 35'(cy_q) - 35'(org_y_q);

  // one restoring division step per cycle
  assign div_sh = 30'(res_q) << k_q;
  assign div_ge = (rem_q >= div_sh);

  assign cell_idx = 27'(mul_p[25:0]) + 27'(qx_q);
  assign idx_out  = (32'(cell_idx) >= 32'(GRID_CELLS));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grs_pkg::ST_CLEAR: begin
        if (clr_q == AW'(GRID_CELLS - 1)) state_d = grs_pkg::ST_IDLE;
      end
      grs_pkg::ST_IDLE: begin
        if (accept && req_i.req_type == grs_pkg::REQ_STEER) state_d = grs_pkg::ST_RR;
      end
      grs_pkg::ST_RR:  state_d = grs_pkg::ST_WR;
      grs_pkg::ST_WR:  state_d = grs_pkg::ST_HR;
      grs_pkg::ST_HR:  state_d = grs_pkg::ST_TOP;
      grs_pkg::ST_TOP: begin
        if (lam_q[16] || steps_q == SW'(MAX_STEPS)) state_d = grs_pkg::ST_DONE;
        else state_d = grs_pkg::ST_MY;
      end
      grs_pkg::ST_MY:  state_d = grs_pkg::ST_SQX;
      grs_pkg::ST_SQX: state_d = grs_pkg::ST_SQY;
      grs_pkg::ST_SQY: state_d = grs_pkg::ST_CHK;
      grs_pkg::ST_CHK: begin
        if (far || dist_sq > {1'b0, rr_q}) state_d = grs_pkg::ST_DONE;
        else state_d = grs_pkg::ST_POS;
      end
      grs_pkg::ST_POS: state_d = grs_pkg::ST_BND;
      grs_pkg::ST_BND: begin
        if (dpx_q >= 34'(wr_q) || dpy_q >= 34'(hr_q)) state_d = grs_pkg::ST_DONE;
        else state_d = grs_pkg::ST_DIVX;
      end
      grs_pkg::ST_DIVX: begin
        if (k_q == 4'd0) state_d = grs_pkg::ST_DIVY;
      end
      grs_pkg::ST_DIVY: begin
        if (k_q == 4'd0) state_d = grs_pkg::ST_IDX;
      end
      grs_pkg::ST_IDX: state_d = grs_pkg::ST_ADR;
      grs_pkg::ST_ADR: begin
        if (idx_out) state_d = grs_pkg::ST_DONE;
        else state_d = grs_pkg::ST_DEC;
      end
      grs_pkg::ST_DEC: begin
        if (rd_q[1]) state_d = grs_pkg::ST_DONE;
        else state_d = grs_pkg::ST_TOP;
      end
      grs_pkg::ST_DONE: state_d = grs_pkg::ST_IDLE;
      default: state_d = grs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and memory port controls
  always_comb begin
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = grs_pkg::CELL_UNKNOWN;
    mem_re    = 1'b0;
    mem_raddr = AW'(cell_idx);
    unique case (state_q)
      grs_pkg::ST_CLEAR: mem_we = 1'b1;
      grs_pkg::ST_IDLE: begin
        // map write transaction; value three stores an obstacle
        if (accept && req_i.req_type == grs_pkg::REQ_MAP_WRITE &&
            32'(req_i.cell_index) < 32'(GRID_CELLS)) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(req_i.cell_index);
          mem_wdata = (req_i.cell_value == 2'd3) ? grs_pkg::CELL_OBSTACLE
                                                 : req_i.cell_value;
        end
      end
      grs_pkg::ST_RR: begin
        mul_en = 1'b1;
        mul_a  = MW'(reach_q);
        mul_b  = MW'(reach_q);
      end
      grs_pkg::ST_WR: begin
        mul_en = 1'b1;
        mul_a  = MW'(gw_q);
        mul_b  = MW'(res_q);
      end
      grs_pkg::ST_HR: begin
        mul_en = 1'b1;
        mul_a  = MW'(gh_q);
        mul_b  = MW'(res_q);
      end
      grs_pkg::ST_TOP: begin
        mul_en = 1'b1;
        mul_a  = dx_q;
        mul_b  = MW'(lam_q);
      end
      grs_pkg::ST_MY: begin
        mul_en = 1'b1;
        mul_a  = dy_q;
        mul_b  = MW'(lam_q);
      end
      grs_pkg::ST_SQX: begin
        mul_en = 1'b1;
        mul_a  = ax;
        mul_b  = ax;
      end
      grs_pkg::ST_SQY: begin
        mul_en = 1'b1;
        mul_a  = ay;
        mul_b  = ay;
      end
      grs_pkg::ST_IDX: begin
        // linear cell index: row times width, column added next cycle
        mul_en = 1'b1;
        mul_a  = MW'(quo_q);
        mul_b  = MW'(gw_q);
      end
      grs_pkg::ST_ADR: mem_re = !idx_out;
      default: ;
    endcase
  end

  // walk datapath
  always_comb begin
    clr_d   = clr_q;
    steps_d = steps_q;
    done_d  = 1'b0;
    out_d   = out_q;
    nx_d    = nx_q;
    ny_d    = ny_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    res_d   = res_q;
    lam_d   = lam_q;
    found_d = found_q;
    stat_d  = stat_q;
    bx_d    = bx_q;
    by_d    = by_q;
    rr_d    = rr_q;
    sx_d    = sx_q;
    wr_d    = wr_q;
    hr_d    = hr_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    dpx_d   = dpx_q;
    dpy_d   = dpy_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    qx_d    = qx_q;
    k_d     = k_q;
    unique case (state_q)
      grs_pkg::ST_CLEAR: clr_d = clr_q + AW'(1);
      grs_pkg::ST_IDLE: begin
        if (accept) begin
          nx_d    = req_i.near_x;
          ny_d    = req_i.near_y;
          dx_d    = 33'(req_i.target_x) - 33'(req_i.near_x);
          dy_d    = 33'(req_i.target_y) - 33'(req_i.near_y);
          // zero cell size acts as one
          res_d   = (csize_q == 17'd0) ? 17'd1 : csize_q;
          lam_d   = (csize_q == 17'd0) ? 17'd1 : csize_q;
          steps_d = '0;
          found_d = 1'b0;
          stat_d  = 1'b0;
        end
      end
      grs_pkg::ST_WR:  rr_d = mul_p[61:0];
      grs_pkg::ST_HR:  wr_d = mul_p[29:0];
      // height bound is only on the multiplier output at the first step
      grs_pkg::ST_TOP: begin
        if (steps_q == '0) hr_d = mul_p[29:0];
      end
      // offset is the product shifted down, floor by arithmetic shift
      grs_pkg::ST_MY:  ox_d = mul_p[48:16];
      grs_pkg::ST_SQX: oy_d = mul_p[48:16];
      grs_pkg::ST_SQY: sx_d = mul_p[61:0];
      grs_pkg::ST_CHK: begin
        cx_d = 34'(nx_q) + 34'(ox_q);
        cy_d = 34'(ny_q) + 34'(oy_q);
      end
      grs_pkg::ST_POS: begin
        dpx_d = (ddx[34] || ddx == 35'sd0) ? 34'd0 : ddx[33:0];
        dpy_d = (ddy[34] || ddy == 35'sd0) ? 34'd0 : ddy[33:0];
      end
      grs_pkg::ST_BND: begin
        rem_d = dpx_q[29:0];
        k_d   = 4'(grs_pkg::DIV_BITS - 1);
      end
      grs_pkg::ST_DIVX: begin
        rem_d = div_ge ? rem_q - div_sh : rem_q;
        quo_d = {quo_q[11:0], div_ge};
        k_d   = k_q - 4'd1;
        if (k_q == 4'd0) begin
          qx_d  = {quo_q[11:0], div_ge};
          rem_d = dpy_q[29:0];
          k_d   = 4'(grs_pkg::DIV_BITS - 1);
        end
      end
      grs_pkg::ST_DIVY: begin
        rem_d = div_ge ? rem_q - div_sh : rem_q;
        quo_d = {quo_q[11:0], div_ge};
        k_d   = k_q - 4'd1;
      end
      grs_pkg::ST_DEC: begin
        if (!rd_q[1]) begin
          found_d = 1'b1;
          bx_d    = cx_q[31:0];
          by_d    = cy_q[31:0];
          stat_d  = stat_q || (rd_q == grs_pkg::CELL_UNKNOWN);
          lam_d   = lam_q + res_q;
          steps_d = steps_q + SW'(1);
        end
      end
      grs_pkg::ST_DONE: begin
        done_d            = 1'b1;
        out_d.found       = found_q;
        out_d.new_x       = found_q ? bx_q : 32'd0;
        out_d.new_y       = found_q ? by_q : 32'd0;
        out_d.path_status = found_q && stat_q;
      end
      default: ;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grs_pkg::ST_CLEAR;
      clr_q   <= '0;
      steps_q <= '0;
      done_q  <= 1'b0;
      org_x_q <= grs_pkg::ORIGIN_RST;
      org_y_q <= grs_pkg::ORIGIN_RST;
      csize_q <= grs_pkg::CELL_SIZE_RST;
      gw_q    <= grs_pkg::GRID_DIM_RST;
      gh_q    <= grs_pkg::GRID_DIM_RST;
      reach_q <= grs_pkg::REACH_RST;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      steps_q <= steps_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          grs_pkg::CFG_ORIGIN_X:    org_x_q <= cfg_data_i;
          grs_pkg::CFG_ORIGIN_Y:    org_y_q <= cfg_data_i;
          grs_pkg::CFG_CELL_SIZE:   csize_q <= cfg_data_i[16:0];
          grs_pkg::CFG_GRID_WIDTH:  gw_q    <= cfg_data_i[12:0];
          grs_pkg::CFG_GRID_HEIGHT: gh_q    <= cfg_data_i[12:0];
          grs_pkg::CFG_REACH_LIMIT: reach_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    nx_q    <= nx_d;
    ny_q    <= ny_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    res_q   <= res_d;
    lam_q   <= lam_d;
    found_q <= found_d;
    stat_q  <= stat_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    rr_q    <= rr_d;
    sx_q    <= sx_d;
    wr_q    <= wr_d;
    hr_q    <= hr_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    dpx_q   <= dpx_d;
    dpy_q   <= dpy_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    qx_q    <= qx_d;
    k_q     <= k_d;
  end

  // grid memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  assign done_o = done_q;
  assign res_o  = out_q;

  `GRS_ASSERT(a_done_src, clk_i, rst_ni, done_o |-> $past(state_q == grs_pkg::ST_DONE))
  `GRS_NEVER(a_empty_zero, clk_i, rst_ni, done_o && !res_o.found && (res_o != '0))
  `GRS_NEVER(a_steps_cap, clk_i, rst_ni, steps_q > SW'(MAX_STEPS))
  `GRS_NEVER(a_wr_in_walk, clk_i, rst_ni, mem_we && state_q != grs_pkg::ST_IDLE && state_q != grs_pkg::ST_CLEAR)

endmodule

// ===== tb/sv/grs_steer_checker.sv =====
// grid ray steer checker: watches the command, result and register channels
// keeps its own occupancy grid and register copy, predicts every steer result
// depends on grs_pkg only
`timescale 1ns / 1ps
module grs_steer_checker #(
  parameter int GRID_CELLS = grs_pkg::GRID_CELLS_DEF,
  parameter int MAX_STEPS  = grs_pkg::MAX_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  grs_pkg::grs_in_t  req_i,
  input  logic              done_i,
  input  grs_pkg::grs_out_t res_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  output int                pending_o,
  output int                fail_cnt_o
);
  import grs_pkg::*;

  logic [1:0]      occ_grid [GRID_CELLS];
  longint          org_x, org_y;
  logic [16:0]     res_cfg;
  logic [12:0]     width_cfg, height_cfg;
  logic [30:0]     reach_cfg;
  grs_out_t        steer_q [$];
  int              fails;

  initial begin
    for (int k = 0; k < GRID_CELLS; k++) occ_grid[k] = CELL_UNKNOWN;
    org_x = 0;
    org_y = 0;
    res_cfg = CELL_SIZE_RST;
    width_cfg = GRID_DIM_RST;
    height_cfg = GRID_DIM_RST;
    reach_cfg = REACH_RST;
    fails = 0;
  end

  assign pending_o  = steer_q.size();
  assign fail_cnt_o = fails;

  function automatic longint unsigned cell_coord(longint pos, longint org,
                                                 longint unsigned step);
    longint d;
    d = pos - org;
    return (d <= 0) ? 64'd0 : longint'(d) / step;
  endfunction

  function automatic grs_out_t walk_steer(grs_in_t rq);
    longint          nx, ny, dx, dy, ox, oy, bx, by;
    longint unsigned step, lam, ax, ay, lim, ci, cj, idx;
    int              steps;
    logic            hit, unk;
    logic [1:0]      cv;
    grs_out_t        r;
    nx = longint'(rq.near_x);
    ny = longint'(rq.near_y);
    dx = longint'(rq.target_x) - nx;
    dy = longint'(rq.target_y) - ny;
    step = (res_cfg == 0) ? 64'd1 : 64'(res_cfg);
    lam = step;
    steps = 0;
    hit = 1'b0;
    unk = 1'b0;
    bx = 0;
    by = 0;
    lim = 64'(reach_cfg);
    while (lam < 65536 && steps < MAX_STEPS) begin
      ox = (longint'(lam) * dx) >>> 16;
      oy = (longint'(lam) * dy) >>> 16;
      ax = (ox < 0) ? -ox : ox;
      ay = (oy < 0) ? -oy : oy;
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) break;
      if (ax * ax + ay * ay > lim * lim) break;
      ci = cell_coord(nx + ox, org_x, step);
      cj = cell_coord(ny + oy, org_y, step);
      if (ci >= width_cfg || cj >= height_cfg) break;
      idx = cj * width_cfg + ci;
      if (idx >= GRID_CELLS) break;
      cv = occ_grid[idx];
      if (cv == CELL_OBSTACLE) break;
      hit = 1'b1;
      bx = nx + ox;
      by = ny + oy;
      if (cv == CELL_UNKNOWN) unk = 1'b1;
      lam += step;
      steps++;
    end
    r.found = hit;
    r.new_x = hit ? bx[31:0] : '0;
    r.new_y = hit ? by[31:0] : '0;
    r.path_status = hit ? unk : 1'b0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    grs_out_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (steer_q.size() == 0) begin
          $error("result transaction with no steer query outstanding");
          fails++;
        end else begin
          want = steer_q.pop_front();
          if (res_i.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, res_i.found);
            fails++;
          end
          if (res_i.new_x !== want.new_x) begin
            $error("new_x: expected %0d, actual %0d", want.new_x, res_i.new_x);
            fails++;
          end
          if (res_i.new_y !== want.new_y) begin
            $error("new_y: expected %0d, actual %0d", want.new_y, res_i.new_y);
            fails++;
          end
          if (res_i.path_status !== want.path_status) begin
            $error("path_status: expected %0d, actual %0d",
                   want.path_status, res_i.path_status);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (req_i.req_type == REQ_STEER) steer_q.push_back(walk_steer(req_i));
        else if (req_i.cell_index < GRID_CELLS)
          occ_grid[req_i.cell_index] <= (req_i.cell_value == 2'd3) ? CELL_OBSTACLE
                                                                    : req_i.cell_value;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIGIN_X:    org_x = longint'($signed(cfg_data_i));
          CFG_ORIGIN_Y:    org_y = longint'($signed(cfg_data_i));
          CFG_CELL_SIZE:   res_cfg = cfg_data_i[16:0];
          CFG_GRID_WIDTH:  width_cfg = cfg_data_i[12:0];
          CFG_GRID_HEIGHT: height_cfg = cfg_data_i[12:0];
          CFG_REACH_LIMIT: reach_cfg = cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/sv/tb_grid_ray_steer_top.sv =====
// top of the grid ray steer testbench: clock, reset, register phases and stimulus
// depends on grs_pkg, grid_ray_steer_top and grs_steer_checker
`timescale 1ns / 1ps
module tb_grid_ray_steer_top;
  import grs_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  grs_in_t  req_i;
  logic     done_o;
  grs_out_t res_o;
  logic     cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  int       pending;
  int       fail_cnt;

  // stimulus-side copy of the registers, only used to aim the queries
  longint   org_x, org_y, res_sz, cols, rows, reach;
  bit       no_gaps;

  grid_ray_steer_top u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  grs_steer_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i, .done_i(done_o),
    .res_i(res_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .fail_cnt_o(fail_cnt)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // generous bound: clearing pass plus worst-case walks
  initial begin
    #20_000_000;
    $display("tb_grid_ray_steer_top: errors");
    $finish;
  end

  // block is idle once no steer result is owed and busy has dropped
  task automatic wait_idle();
    @(negedge clk_i);
    start_i = 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_ORIGIN_X:    org_x = longint'($signed(val));
      CFG_ORIGIN_Y:    org_y = longint'($signed(val));
      CFG_CELL_SIZE:   res_sz = (val[16:0] == 0) ? 1 : val[16:0];
      CFG_GRID_WIDTH:  cols = val[12:0];
      CFG_GRID_HEIGHT: rows = val[12:0];
      default:         reach = val[30:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_phase(logic [31:0] ox, logic [31:0] oy, logic [31:0] cs,
                            logic [31:0] w, logic [31:0] h, logic [31:0] rl);
    wait_idle();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_CELL_SIZE, cs);
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    write_reg(CFG_REACH_LIMIT, rl);
  endtask

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // one command transaction: held until the block takes it
  task automatic issue(grs_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    req_i = item;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic grs_in_t map_write(logic [19:0] idx, logic [1:0] val);
    grs_in_t it;
    it = grs_in_t'($urandom());
    it.near_x = $urandom();
    it.target_y = $urandom();
    it.req_type = REQ_MAP_WRITE;
    it.cell_index = idx;
    it.cell_value = val;
    return it;
  endfunction

  function automatic grs_in_t steer(longint nx, longint ny, longint tx, longint ty);
    grs_in_t it;
    it = '0;
    it.cell_index = $urandom();
    it.cell_value = $urandom();
    it.req_type = REQ_STEER;
    it.near_x = nx[31:0];
    it.near_y = ny[31:0];
    it.target_x = tx[31:0];
    it.target_y = ty[31:0];
    return it;
  endfunction

  // random item shaped by the current registers
  function automatic grs_in_t random_item();
    longint ext_x, ext_y, span, nx, ny, cells;
    int     r, v;
    r = $urandom_range(0, 99);
    ext_x = cols * res_sz;
    ext_y = rows * res_sz;
    if (ext_x > 64'h100_0000) ext_x = 64'h100_0000;
    if (ext_y > 64'h100_0000) ext_y = 64'h100_0000;
    if (r < 35) begin
      // map write, mostly inside the cells in use
      cells = cols * rows;
      if (cells > 1048576) cells = 1048576;
      v = $urandom_range(0, 99);
      v = (v < 55) ? CELL_FREE : (v < 75) ? CELL_UNKNOWN : (v < 95) ? CELL_OBSTACLE : 3;
      if ($urandom_range(0, 9) < 8)
        return map_write(20'($urandom_range(0, int'(cells - 1))), 2'(v));
      return map_write(20'($urandom()), 2'(v));
    end
    if (r < 45)  // noise: any coordinates at all
      return steer(longint'($signed($urandom())), longint'($signed($urandom())),
                   longint'($signed($urandom())), longint'($signed($urandom())));
    // query from a point on the map towards a point within a few reaches
    span = 2 * reach + 64'h10000;
    if (span > 64'h4000_0000) span = 64'h4000_0000;
    nx = org_x + $urandom_range(0, int'(ext_x)) - 2;
    ny = org_y + $urandom_range(0, int'(ext_y)) - 2;
    return steer(nx, ny, nx + longint'($urandom_range(0, int'(2 * span))) - span,
                 ny + longint'($urandom_range(0, int'(2 * span))) - span);
  endfunction

  task automatic run_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
      issue(random_item());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ORIGIN_X;
    cfg_data_i = '0;
    org_x = 0;
    org_y = 0;
    res_sz = CELL_SIZE_RST;
    cols = GRID_DIM_RST;
    rows = GRID_DIM_RST;
    reach = REACH_RST;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part on the reset registers; the clearing pass holds busy first
    wait_idle();
    issue(map_write(20'd0, CELL_FREE));
    issue(map_write(20'd1, 2'd3));                 // value three stores an obstacle
    issue(map_write(20'hFFFFF, CELL_FREE));
    issue(map_write(20'd1024, CELL_FREE));
    issue(steer(0, 0, 0, 0));                      // zero-length segment
    issue(steer(0, 0, 64'h10000, 0));              // runs into the obstacle
    issue(steer(0, 0, 0, 64'h10000));              // unknown cells on the way
    issue(steer(-64'sh8000_0000, 0, 64'h7FFF_FFFF, 0));  // offset too large
    issue(steer(-64'h40000, -64'h40000, -64'h40000, -64'h40000));  // clamped to cell 0
    issue(steer(64'h7FFF_FFFF, 0, 64'h7FFF_FFFF, 0));    // beyond the map
    issue(steer(1024 * 3277, 0, 1024 * 3277 - 64'h8000, 0));
    issue(steer(3000, 3000, 3000 + 64'h8000, 3000 - 64'h8000));
    issue(map_write(20'd2, CELL_OBSTACLE));
    issue(map_write(20'd3, CELL_UNKNOWN));
    issue(steer(100, 100, -64'h20000, 64'h20000));
    run_random(90);

    // small map, fine grid
    load_phase(32'd0, 32'd0, 32'd4096, 32'd32, 32'd32, 32'h2_0000);
    run_random(105);
    // extreme origins, unit cell size, oversized map, widest reach
    load_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd4096, 32'd4096, 32'h7FFF_FFFF);
    run_random(80);
    // whole-metre cells: lambda is one at once, nothing found
    load_phase($urandom(), $urandom(), 32'd65536, 32'd1, 32'd1, 32'd0);
    run_random(60);
    // zero cell size acts as one
    load_phase(32'h1_0000, 32'hFFFF_0000, 32'd0, 32'd16, 32'd16, 32'h1_0000);
    run_random(80);
    load_phase($urandom(), $urandom(), 32'd8192, 32'd64, 32'd16, $urandom() >> 12);
    run_random(110);
    // largest cell size, grid and reach values
    load_phase(32'd0, 32'd0, 32'h1_FFFF, 32'h1FFF, 32'h1FFF, 32'hFFFF_FFFF);
    run_random(80);
    load_phase(32'hFFF0_0000, 32'h0010_0000, 32'd2048, 32'd128, 32'd128, 32'h3_0000);
    run_random(230);

    @(negedge clk_i);
    start_i = 1'b0;
    wait_idle();
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_grid_ray_steer_top: clean");
    end else begin
      $display("tb_grid_ray_steer_top: errors");
    end
    $finish;
  end
endmodule
